@@ rtl/mia_pkg.sv @@
package mia_pkg;

	localparam int SeqW   = 32;
	localparam int TimeW  = 48;
	localparam int ByteW  = 16;
	localparam int TotalW = 40;
	localparam int FuncW  = 3;

	localparam logic [FuncW-1:0] FUNC_OPEN  = 3'd0;
	localparam logic [FuncW-1:0] FUNC_SENT  = 3'd1;
	localparam logic [FuncW-1:0] FUNC_ACKED = 3'd2;
	localparam logic [FuncW-1:0] FUNC_LOST  = 3'd3;
	localparam logic [FuncW-1:0] FUNC_CHECK = 3'd4;

	localparam logic [SeqW-1:0]   SEQ_HALF  = 32'h8000_0000;
	localparam logic [SeqW-1:0]   COUNT_MAX = 32'hFFFF_FFFF;
	localparam logic [TotalW-1:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;

	typedef struct packed {
		logic [FuncW-1:0] func;
		logic [TimeW-1:0] event_us;
		logic [SeqW-1:0]  sequence_req;
		logic [ByteW-1:0] packet_bytes;
		logic [TimeW-1:0] interval_end;
	} req_t;

	typedef struct packed {
		logic              all_sent;
		logic              all_accounted;
		logic [SeqW-1:0]   packets_sent;
		logic [SeqW-1:0]   packets_accounted;
		logic [TotalW-1:0] sent_total;
		logic [TotalW-1:0] acked_total;
		logic [TotalW-1:0] lost_total;
		logic [TimeW-1:0]  send_span;
		logic [TimeW-1:0]  ack_span;
	} rsp_t;

	typedef struct packed {
		logic [TimeW-1:0]  end_mark;
		logic [SeqW-1:0]   first_seq;
		logic [SeqW-1:0]   last_seq;
		logic [SeqW-1:0]   accounted_seq;
		logic [SeqW-1:0]   sent_count;
		logic [SeqW-1:0]   accounted_count;
		logic [TotalW-1:0] bytes_out;
		logic [TotalW-1:0] bytes_in;
		logic [TotalW-1:0] bytes_dropped;
		logic [TimeW-1:0]  first_send_time;
		logic [TimeW-1:0]  last_send_time;
		logic [TimeW-1:0]  first_ack_time;
		logic [TimeW-1:0]  last_ack_time;
	} state_t;

	// serial-number a > b over 32 bits
	function automatic logic ser_gt(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
		logic [SeqW-1:0] d;
		begin
			d = a - b;
			ser_gt = ((d != '0) && !d[SeqW-1]) || ((d == SEQ_HALF) && (a < b));
		end
	endfunction

	function automatic logic ser_ge(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
		ser_ge = (a == b) || ser_gt(a, b);
	endfunction

	function automatic logic [TotalW-1:0] total_add(input logic [TotalW-1:0] acc,
			input logic [ByteW-1:0] add);
		logic [TotalW:0] s;
		begin
			s = {1'b0, acc} + {{(TotalW+1-ByteW){1'b0}}, add};
			total_add = s[TotalW] ? TOTAL_MAX : s[TotalW-1:0];
		end
	endfunction

endpackage

@@ rtl/mia_core.sv @@
module mia_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           upd_en,
	input  mia_pkg::req_t  item,
	output mia_pkg::rsp_t  result
);

	mia_pkg::state_t st_q;
	mia_pkg::state_t st_nxt;

	logic [mia_pkg::SeqW-1:0]  seq;
	logic [mia_pkg::TimeW-1:0] t;
	logic                      in_range;
	logic                      beyond;
	logic                      ge_first;
	logic                      ge_last;
	logic [mia_pkg::SeqW-1:0]  d;
	logic [mia_pkg::SeqW+1:0]  acc_sum;
	logic [mia_pkg::SeqW-1:0]  acc_clamped;

	assign seq      = item.sequence_req;
	assign t        = item.event_us;
	assign ge_first = mia_pkg::ser_ge(seq, st_q.first_seq);
	assign ge_last  = mia_pkg::ser_ge(seq, st_q.last_seq);
	assign in_range = ge_first && mia_pkg::ser_ge(st_q.last_seq, seq);
	assign beyond   = mia_pkg::ser_gt(seq, st_q.last_seq);

	// signed step from the last accounted sequence, clamped to the count range
	assign d       = seq - st_q.accounted_seq;
	assign acc_sum = {2'b00, st_q.accounted_count} + {{2{d[mia_pkg::SeqW-1]}}, d};

	always_comb begin
		if (acc_sum[mia_pkg::SeqW+1])
			acc_clamped = '0;
		else if (acc_sum[mia_pkg::SeqW])
			acc_clamped = mia_pkg::COUNT_MAX;
		else
			acc_clamped = acc_sum[mia_pkg::SeqW-1:0];
	end

	always_comb begin
		st_nxt = st_q;
		case (item.func)
			mia_pkg::FUNC_OPEN: begin
				st_nxt = '0;
				st_nxt.end_mark = item.interval_end;
			end
			mia_pkg::FUNC_SENT: begin
				if (st_q.sent_count == '0) begin
					st_nxt.first_send_time = t;
					st_nxt.first_seq       = seq;
					st_nxt.accounted_seq   = seq - 32'd1;
				end
				st_nxt.last_send_time = t;
				st_nxt.last_seq       = seq;
				if (st_q.sent_count != mia_pkg::COUNT_MAX)
					st_nxt.sent_count = st_q.sent_count + 32'd1;
				st_nxt.bytes_out = mia_pkg::total_add(st_q.bytes_out, item.packet_bytes);
			end
			mia_pkg::FUNC_ACKED, mia_pkg::FUNC_LOST: begin
				if (in_range) begin
					st_nxt.accounted_count = acc_clamped;
					st_nxt.accounted_seq   = seq;
					if (item.func == mia_pkg::FUNC_ACKED) begin
						st_nxt.bytes_in = mia_pkg::total_add(st_q.bytes_in,
							item.packet_bytes);
						st_nxt.last_ack_time = t;
					end else begin
						st_nxt.bytes_dropped = mia_pkg::total_add(st_q.bytes_dropped,
							item.packet_bytes);
					end
				end else if (beyond) begin
					st_nxt.accounted_count = st_q.sent_count;
					st_nxt.accounted_seq   = st_q.last_seq;
				end
				if (ge_first && (st_q.first_ack_time == '0))
					st_nxt.first_ack_time = t;
				// an in-range ack already wrote t here, so latching again is harmless
				if (ge_last && (st_q.last_ack_time == '0))
					st_nxt.last_ack_time = t;
			end
			default: begin
				st_nxt = st_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (upd_en)
			st_q <= st_nxt;
	end

	always_comb begin
		result.all_sent          = (t >= st_nxt.end_mark);
		result.all_accounted     = result.all_sent &&
			(st_nxt.accounted_count == st_nxt.sent_count);
		result.packets_sent      = st_nxt.sent_count;
		result.packets_accounted = st_nxt.accounted_count;
		result.sent_total        = st_nxt.bytes_out;
		result.acked_total       = st_nxt.bytes_in;
		result.lost_total        = st_nxt.bytes_dropped;
		result.send_span         = st_nxt.last_send_time - st_nxt.first_send_time;
		result.ack_span          = st_nxt.last_ack_time - st_nxt.first_ack_time;
	end

endmodule

@@ rtl/monitor_interval_accounting.sv @@
// Monitor interval accounting for one congestion-control interval.
// Request channel (req_valid / req_ready / req): one event item per
// handshake - open, packet sent, packet acked, packet lost or time check.
// Response channel (rsp_valid / rsp_ready / rsp): exactly one result item
// per event, giving the status flags and all counters after the event.
// Path: an accepted item sits in the input register while the interval
// state updates, and the result lands in the output register once that
// register is free.
// Throughput: one item per cycle while rsp_ready stays high; the state
// update between the input and output registers is combinational.
// Reset: arst_n clears all interval state to zero (no interval open, end
// time zero) and empties both registers.
// Stall: while rsp_valid is high and rsp_ready low the result holds, the
// item in the input register waits and req_ready drops once that register
// is occupied; nothing is lost or repeated.
module monitor_interval_accounting (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mia_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mia_pkg::rsp_t rsp
);

	logic          valid_s1;
	mia_pkg::req_t req_s1;
	logic          advance;
	logic          out_free;
	mia_pkg::rsp_t result;
	logic          rsp_valid_q;
	mia_pkg::rsp_t rsp_q;

	// Advance the held item when the output register is empty or draining
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign advance   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;

	// Input register: take a new item whenever it is empty or the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_ready)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
	end

	// State update commits only when the result is written out
	mia_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (advance),
		.item   (req_s1),
		.result (result)
	);

	// Output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (out_free)
			rsp_valid_q <= advance;
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An item that moves on always leaves a result behind
	a_advance_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("advanced item left no result");

	// Completion implies the interval end has been reached
	a_accounted_needs_sent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (!rsp_q.all_accounted || rsp_q.all_sent))
		else $error("all_accounted without all_sent");

	// An open clears every counter
	a_open_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_s1.func == mia_pkg::FUNC_OPEN)) |=>
		((rsp_q.packets_sent == '0) && (rsp_q.packets_accounted == '0) &&
		(rsp_q.sent_total == '0) && (rsp_q.acked_total == '0) &&
		(rsp_q.lost_total == '0)))
		else $error("open left counters set");

	// A sent event always leaves a nonzero sent count
	a_sent_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_s1.func == mia_pkg::FUNC_SENT)) |=>
		(rsp_q.packets_sent != '0))
		else $error("sent event not counted");

endmodule

@@ tb/sv/tb_monitor_interval_accounting.sv @@
`timescale 1ns / 100ps

module tb_monitor_interval_accounting;

	// The selector values above the time check are unused by the block and must
	// behave as a time check.
	localparam logic [mia_pkg::FuncW-1:0] FUNC_SPARE_A = 3'd5;
	localparam logic [mia_pkg::FuncW-1:0] FUNC_SPARE_B = 3'd6;
	localparam logic [mia_pkg::FuncW-1:0] FUNC_SPARE_C = 3'd7;

	localparam logic [mia_pkg::TimeW-1:0] TIME_TOP = '1;
	localparam logic [mia_pkg::SeqW-1:0]  SEQ_TOP  = '1;

	localparam int RANDOM_ITEMS = 1950;
	localparam int DIRECTED_ITEMS = 24;
	// Cycles without any item moving on either channel before the run is
	// declared hung. A correct run never comes near this: stalls are short
	// random bursts and the block moves an item every cycle it can.
	localparam int QUIET_LIMIT = 2000;

	// Expected results of the interval, kept in step with every accepted event.
	class interval_scoreboard;
		mia_pkg::state_t ivl;
		mia_pkg::rsp_t   pending_results[$];
		int              failures;

		function new();
			ivl = '0;
			failures = 0;
		endfunction

		// 32-bit serial "a is after b"; half-way apart counts as after only when
		// a is the smaller plain number.
		function bit seq_after(logic [mia_pkg::SeqW-1:0] a, logic [mia_pkg::SeqW-1:0] b);
			if (a > b)
				return (a - b) < mia_pkg::SEQ_HALF;
			if (a < b)
				return (b - a) >= mia_pkg::SEQ_HALF;
			return 1'b0;
		endfunction

		function bit seq_at_or_after(logic [mia_pkg::SeqW-1:0] a,
				logic [mia_pkg::SeqW-1:0] b);
			return (a == b) || seq_after(a, b);
		endfunction

		function logic [mia_pkg::TotalW-1:0] add_bytes(logic [mia_pkg::TotalW-1:0] acc,
				logic [mia_pkg::ByteW-1:0] n);
			logic [mia_pkg::TotalW:0] sum;
			sum = {1'b0, acc} + n;
			return sum[mia_pkg::TotalW] ? mia_pkg::TOTAL_MAX : sum[mia_pkg::TotalW-1:0];
		endfunction

		function void account_feedback(bit acked, logic [mia_pkg::TimeW-1:0] t,
				logic [mia_pkg::SeqW-1:0] seq, logic [mia_pkg::ByteW-1:0] n);
			logic [mia_pkg::SeqW-1:0] step;
			longint                   moved;
			if (seq_at_or_after(seq, ivl.first_seq) && seq_at_or_after(ivl.last_seq, seq)) begin
				step = seq - ivl.accounted_seq;
				moved = longint'(ivl.accounted_count) + longint'($signed(step));
				if (moved < 0)
					moved = 0;
				if (moved > longint'(mia_pkg::COUNT_MAX))
					moved = longint'(mia_pkg::COUNT_MAX);
				ivl.accounted_count = moved[mia_pkg::SeqW-1:0];
				ivl.accounted_seq = seq;
				if (acked) begin
					ivl.bytes_in = add_bytes(ivl.bytes_in, n);
					ivl.last_ack_time = t;
				end else begin
					ivl.bytes_dropped = add_bytes(ivl.bytes_dropped, n);
				end
			end else if (seq_after(seq, ivl.last_seq)) begin
				ivl.accounted_count = ivl.sent_count;
				ivl.accounted_seq = ivl.last_seq;
			end
			if (seq_at_or_after(seq, ivl.first_seq) && ivl.first_ack_time == '0)
				ivl.first_ack_time = t;
			if (seq_at_or_after(seq, ivl.last_seq) && ivl.last_ack_time == '0)
				ivl.last_ack_time = t;
		endfunction

		function void note_event(mia_pkg::req_t ev);
			mia_pkg::rsp_t want;
			case (ev.func)
				mia_pkg::FUNC_OPEN: begin
					ivl = '0;
					ivl.end_mark = ev.interval_end;
				end
				mia_pkg::FUNC_SENT: begin
					if (ivl.sent_count == '0) begin
						ivl.first_send_time = ev.event_us;
						ivl.first_seq = ev.sequence_req;
						ivl.accounted_seq = ev.sequence_req - 1'b1;
					end
					ivl.last_send_time = ev.event_us;
					ivl.last_seq = ev.sequence_req;
					if (ivl.sent_count != mia_pkg::COUNT_MAX)
						ivl.sent_count = ivl.sent_count + 1'b1;
					ivl.bytes_out = add_bytes(ivl.bytes_out, ev.packet_bytes);
				end
				mia_pkg::FUNC_ACKED: account_feedback(1'b1, ev.event_us, ev.sequence_req,
					ev.packet_bytes);
				mia_pkg::FUNC_LOST: account_feedback(1'b0, ev.event_us, ev.sequence_req,
					ev.packet_bytes);
				default: ;
			endcase
			want.all_sent = ev.event_us >= ivl.end_mark;
			want.all_accounted = want.all_sent && (ivl.accounted_count == ivl.sent_count);
			want.packets_sent = ivl.sent_count;
			want.packets_accounted = ivl.accounted_count;
			want.sent_total = ivl.bytes_out;
			want.acked_total = ivl.bytes_in;
			want.lost_total = ivl.bytes_dropped;
			want.send_span = ivl.last_send_time - ivl.first_send_time;
			want.ack_span = ivl.last_ack_time - ivl.first_ack_time;
			pending_results = {pending_results, want};
		endfunction

		function bit field_differs(string name, logic [mia_pkg::TimeW-1:0] want,
				logic [mia_pkg::TimeW-1:0] got);
			if (want === got)
				return 1'b0;
			if (failures < 10)
				$display("mismatch in %s: expected %0h, got %0h", name, want, got);
			return 1'b1;
		endfunction

		function void check_result(mia_pkg::rsp_t got);
			mia_pkg::rsp_t want;
			bit            bad;
			if (pending_results.size() == 0) begin
				if (failures < 10)
					$display("result with nothing expected: %h", got);
				failures++;
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			bad = 1'b0;
			bad |= field_differs("all_sent", want.all_sent, got.all_sent);
			bad |= field_differs("all_accounted", want.all_accounted, got.all_accounted);
			bad |= field_differs("packets_sent", want.packets_sent, got.packets_sent);
			bad |= field_differs("packets_accounted", want.packets_accounted,
				got.packets_accounted);
			bad |= field_differs("sent_total", want.sent_total, got.sent_total);
			bad |= field_differs("acked_total", want.acked_total, got.acked_total);
			bad |= field_differs("lost_total", want.lost_total, got.lost_total);
			bad |= field_differs("send_span", want.send_span, got.send_span);
			bad |= field_differs("ack_span", want.ack_span, got.ack_span);
			if (bad)
				failures++;
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	mia_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	mia_pkg::rsp_t rsp;

	interval_scoreboard board;
	int items_issued = 0;
	int quiet_cycles = 0;
	// While set, neither side idles: gives a stretch at full rate.
	bit calm = 1'b0;

	monitor_interval_accounting dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// Result side: drop ready at random about 28 percent of the time, never while calm.
	always @(posedge clk) begin
		rsp_ready <= calm || ($urandom_range(0, 99) >= 28);
	end

	// Watch both channels at the edge. Values read here are those sampled by
	// the block at the same edge, since every input changes through
	// nonblocking assignments and every output settles only after the edge.
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready)
			board.note_event(req);
		if (arst_n && rsp_valid && rsp_ready)
			board.check_result(rsp);
		if (arst_n && ((req_valid && req_ready) || (rsp_valid && rsp_ready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Hang detection: end the run once nothing has moved for too long.
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	function automatic logic [mia_pkg::TimeW-1:0] rand_time();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[mia_pkg::TimeW-1:0];
	endfunction

	function automatic logic [mia_pkg::ByteW-1:0] rand_bytes();
		logic [31:0] raw;
		raw = $urandom;
		return raw[mia_pkg::ByteW-1:0];
	endfunction

	function automatic logic [mia_pkg::FuncW-1:0] rand_func();
		logic [31:0] raw;
		raw = $urandom;
		return raw[mia_pkg::FuncW-1:0];
	endfunction

	// Offer one event item, idling first at random, and hold it until taken.
	task automatic issue(input logic [mia_pkg::FuncW-1:0] f,
			input logic [mia_pkg::TimeW-1:0] t, input logic [mia_pkg::SeqW-1:0] s,
			input logic [mia_pkg::ByteW-1:0] n, input logic [mia_pkg::TimeW-1:0] e);
		mia_pkg::req_t item;
		item.func = f;
		item.event_us = t;
		item.sequence_req = s;
		item.packet_bytes = n;
		item.interval_end = e;
		while (!calm && $urandom_range(0, 99) < 28) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		items_issued++;
	endtask

	// Hold the request side idle until every expected result has come back.
	task automatic await_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending_results.size() != 0);
	endtask

	initial begin
		logic [mia_pkg::TimeW-1:0] now;
		logic [mia_pkg::TimeW-1:0] iend;
		logic [mia_pkg::SeqW-1:0]  base;
		logic [mia_pkg::SeqW-1:0]  s;
		logic [mia_pkg::FuncW-1:0] f;
		int                        n_pkts;
		int                        sent;
		int                        fb;
		int                        pick;
		int                        episodes;

		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Time check straight after reset: end time zero, so all sent and
		// all accounted.
		issue(mia_pkg::FUNC_CHECK, '0, '0, '0, '0);
		// Interval that ends only at the largest time value, sequence numbers running across the wrap.
		issue(mia_pkg::FUNC_OPEN, '0, '0, '0, TIME_TOP);
		issue(mia_pkg::FUNC_SENT, 48'd5, SEQ_TOP - 1'b1, '1, '0);
		issue(mia_pkg::FUNC_SENT, 48'd6, SEQ_TOP, '0, '0);
		issue(mia_pkg::FUNC_SENT, 48'd7, '0, 16'd1, '0);
		issue(mia_pkg::FUNC_SENT, 48'd8, 32'd1, 16'h8000, '0);
		// Ack at time zero leaves the ack times unlatched, so the duplicate
		// after it latches again.
		issue(mia_pkg::FUNC_ACKED, '0, SEQ_TOP - 1'b1, 16'd100, '0);
		issue(mia_pkg::FUNC_ACKED, 48'd10, SEQ_TOP - 1'b1, 16'd100, '0);
		issue(mia_pkg::FUNC_ACKED, 48'd11, 32'd1, 16'd200, '0);
		// Older loss steps the count back.
		issue(mia_pkg::FUNC_LOST, 48'd12, '0, '1, '0);
		// Beyond the range: everything counts as accounted.
		issue(mia_pkg::FUNC_ACKED, 48'd13, 32'd5, 16'd3, '0);
		// Exactly half the sequence space away from the last sent packet.
		issue(mia_pkg::FUNC_ACKED, 48'd14, 32'd1 + mia_pkg::SEQ_HALF, 16'd7, '0);
		issue(mia_pkg::FUNC_CHECK, TIME_TOP, SEQ_TOP, '1, TIME_TOP);
		// Unused selectors behave as a time check.
		issue(FUNC_SPARE_A, TIME_TOP - 1'b1, 32'h1234_5678, 16'hA5A5, '0);
		issue(FUNC_SPARE_B, '0, mia_pkg::SEQ_HALF, '0, TIME_TOP);
		issue(FUNC_SPARE_C, 48'h8000_0000_0000, '0, '1, 48'h5555_5555_5555);
		// Send times running backwards, then a count driven below zero.
		issue(mia_pkg::FUNC_OPEN, 48'd100, '0, '0, '0);
		issue(mia_pkg::FUNC_SENT, TIME_TOP, 32'd10, '1, '0);
		issue(mia_pkg::FUNC_SENT, 48'd3, 32'd20, 16'd1, '0);
		issue(mia_pkg::FUNC_ACKED, 48'd50, 32'd30, 16'd9, '0);
		issue(mia_pkg::FUNC_SENT, 48'd4, 32'd15, 16'd2, '0);
		issue(mia_pkg::FUNC_ACKED, 48'd51, 32'd12, 16'd4, '0);
		issue(mia_pkg::FUNC_LOST, 48'd52, 32'd15, 16'd5, '0);
		issue(mia_pkg::FUNC_OPEN, '0, '0, '0, 48'd200);

		// Random part: mostly whole intervals (open, sends interleaved with
		// feedback), with some noise and broken feedback mixed in.
		now = 48'd300;
		episodes = 0;
		while (items_issued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			calm = (items_issued >= 900 && items_issued < 1100);
			if ($urandom_range(0, 7) == 0)
				now = rand_time();
			else
				now = now + $urandom_range(0, 50);
			iend = ($urandom_range(0, 9) == 0) ? rand_time() : now + $urandom_range(0, 600);
			issue(mia_pkg::FUNC_OPEN, now, $urandom, rand_bytes(), iend);

			base = ($urandom_range(0, 3) == 0) ? SEQ_TOP - $urandom_range(0, 8) : $urandom;
			n_pkts = $urandom_range(1, 12);
			sent = 0;
			fb = 0;
			while (sent < n_pkts || fb < n_pkts) begin
				now = now + $urandom_range(0, 30);
				if (sent < n_pkts && (fb >= sent || $urandom_range(0, 2) == 0)) begin
					issue(mia_pkg::FUNC_SENT, now, base + sent, rand_bytes(), rand_time());
					sent++;
				end else begin
					pick = $urandom_range(0, 15);
					if (pick < 10 && fb < sent) begin
						s = base + fb;
						fb++;
					end else if (pick < 12) begin
						s = base + fb - 1;
					end else if (pick < 14) begin
						s = base + $urandom_range(0, n_pkts);
					end else if (pick < 15) begin
						s = base + sent + $urandom_range(0, 100);
					end else begin
						s = $urandom;
					end
					f = ($urandom_range(0, 3) == 0) ? mia_pkg::FUNC_LOST : mia_pkg::FUNC_ACKED;
					issue(f, now, s, rand_bytes(), rand_time());
				end
			end
			if ($urandom_range(0, 1) == 0)
				issue(mia_pkg::FUNC_CHECK, now + $urandom_range(0, 400), $urandom,
					rand_bytes(), rand_time());
			// Noise: any selector, any fields.
			repeat ($urandom_range(0, 2)) begin
				f = rand_func();
				issue(f, rand_time(), $urandom, rand_bytes(), rand_time());
			end
			episodes++;
			if (episodes == 3 || $urandom_range(0, 9) == 0)
				await_results();
		end
		calm = 1'b0;

		// Drain, allow the block's latency to pass, then judge.
		await_results();
		repeat (8) @(posedge clk);
		if (board.pending_results.size() != 0) begin
			$display("%0d results never arrived", board.pending_results.size());
			board.failures += board.pending_results.size();
		end
		if (board.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mia_pkg.sv
rtl/mia_core.sv
rtl/monitor_interval_accounting.sv
tb/sv/tb_monitor_interval_accounting.sv
